/* rtl/lifo_stack_with_purge_unit_macros.svh */
// ----------------------------------------------------------------------------
// LIFO stack with purge - assertion macros
// Shared property forms for the port checker. Each macro expects signals
// named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_PURGE_UNIT_MACROS_SVH
`define LIFO_STACK_WITH_PURGE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSP_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lifo stack check failed");

// Next-cycle implication, disabled during reset.
`define LSP_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lifo stack check failed");

`endif

/* rtl/lsp_pkg.sv */
// ----------------------------------------------------------------------------
// LIFO stack with purge - package
// Field widths, command codes, controller states and the control and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int DATA_BITS  = 64;
  localparam int CMD_BITS   = 2;
  localparam int LEVEL_BITS = 7;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PURGE = 2'd2,
    CMD_NOP   = 2'd3
  } lsp_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PURGE,
    ST_RESULT
  } lsp_state_t;

  typedef struct packed {
    logic     start;
    lsp_cmd_t op;
    logic     purge_run;
    logic     load_out;
  } lsp_ctl_t;

  typedef struct packed {
    logic purge_done;
  } lsp_sts_t;

endpackage

/* rtl/lsp_ifs.sv */
// ----------------------------------------------------------------------------
// LIFO stack with purge - channel interfaces
// Command channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsp_in_if;
  import lsp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  cmd;
  logic [DATA_BITS-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface lsp_out_if;
  import lsp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DATA_BITS-1:0]  top_value;
  logic                  stack_empty;
  logic [LEVEL_BITS-1:0] fill_level;
  logic [LEVEL_BITS-1:0] removed_count;
  logic                  overflow;
  logic                  underflow;

  modport source (output valid, output top_value, output stack_empty, output fill_level,
                  output removed_count, output overflow, output underflow, input ready);
  modport sink   (input valid, input top_value, input stack_empty, input fill_level,
                  input removed_count, input overflow, input underflow, output ready);
endinterface

/* rtl/lsp_datapath.sv */
// ----------------------------------------------------------------------------
// LIFO stack with purge - datapath
// Entry memory, fill counter, cached top word, purge compaction pointers
// and the result register.
// ----------------------------------------------------------------------------
module lsp_datapath #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lsp_pkg::lsp_ctl_t             ctl,
  output lsp_pkg::lsp_sts_t             sts,
  input  logic [lsp_pkg::DATA_BITS-1:0] value,
  output logic [lsp_pkg::DATA_BITS-1:0] top_value,
  output logic                          stack_empty,
  output logic [lsp_pkg::LEVEL_BITS-1:0] fill_level,
  output logic [lsp_pkg::LEVEL_BITS-1:0] removed_count,
  output logic                          overflow,
  output logic                          underflow
);
  import lsp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_LEVEL = CW'(DEPTH);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rd_data;

  logic [WORD_BITS-1:0] word;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_m2;
  logic [CW-1:0]        rd_ptr;
  logic [CW-1:0]        wr_ptr;
  logic [CW-1:0]        removed;
  logic [WORD_BITS-1:0] top_reg;
  logic [WORD_BITS-1:0] top_now;
  logic [WORD_BITS-1:0] target;
  logic [WORD_BITS-1:0] last_kept;
  logic                 pop_pending;
  logic                 chk_valid;
  logic                 ovf;
  logic                 unf;
  logic                 is_full;
  logic                 is_empty;
  logic                 more;
  logic                 keep;

  assign word     = value[WORD_BITS-1:0];
  assign count_m2 = count - CW'(2);
  assign is_full  = (count == FULL_LEVEL);
  assign is_empty = (count == '0);
  assign more     = (rd_ptr != count);
  assign keep     = chk_valid && (rd_data != target);
  assign top_now  = pop_pending ? rd_data : top_reg;

  assign sts.purge_done = !more && !chk_valid;

  // memory port steering
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = count[AW-1:0];
    wdata  = word;
    raddr  = rd_ptr[AW-1:0];
    if (ctl.start && ctl.op == CMD_PUSH && !is_full) begin
      mem_we = 1'b1;
    end
    if (ctl.start && ctl.op == CMD_POP && count >= CW'(2)) begin
      // fetch the entry that becomes the new top
      mem_re = 1'b1;
      raddr  = count_m2[AW-1:0];
    end
    if (ctl.purge_run) begin
      mem_re = more;
      mem_we = keep;
      waddr  = wr_ptr[AW-1:0];
      wdata  = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      pop_pending <= 1'b0;
      chk_valid   <= 1'b0;
    end else begin
      if (ctl.start) begin
        case (ctl.op)
          CMD_PUSH: begin
            if (!is_full) count <= count + CW'(1);
          end
          CMD_POP: begin
            if (!is_empty) begin
              count       <= count - CW'(1);
              pop_pending <= (count >= CW'(2));
            end
          end
          CMD_PURGE: chk_valid <= 1'b0;
          default: ;
        endcase
      end
      if (ctl.purge_run) begin
        chk_valid <= more;
        if (sts.purge_done) count <= wr_ptr;
      end
      if (ctl.load_out) begin
        pop_pending <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      ovf     <= (ctl.op == CMD_PUSH) && is_full;
      unf     <= (ctl.op == CMD_POP) && is_empty;
      removed <= '0;
      if (ctl.op == CMD_PUSH && !is_full) top_reg <= word;
      if (ctl.op == CMD_PURGE) begin
        target <= word;
        rd_ptr <= '0;
        wr_ptr <= '0;
      end
    end
    if (ctl.purge_run) begin
      if (more) rd_ptr <= rd_ptr + CW'(1);
      // compact survivors toward the bottom
      if (keep) begin
        wr_ptr    <= wr_ptr + CW'(1);
        last_kept <= rd_data;
      end
      if (sts.purge_done) begin
        removed <= count - wr_ptr;
        top_reg <= last_kept;
      end
    end
    if (ctl.load_out) begin
      top_reg       <= top_now;
      top_value     <= is_empty ? '0 : DATA_BITS'(top_now);
      stack_empty   <= is_empty;
      fill_level    <= LEVEL_BITS'(count);
      removed_count <= LEVEL_BITS'(removed);
      overflow      <= ovf;
      underflow     <= unf;
    end
  end

endmodule

/* rtl/lsp_controller.sv */
// ----------------------------------------------------------------------------
// LIFO stack with purge - controller
// Sequences intake, the purge walk and the hand-off to the result register.
// ----------------------------------------------------------------------------
module lsp_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsp_pkg::lsp_cmd_t in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output lsp_pkg::lsp_ctl_t ctl,
  input  lsp_pkg::lsp_sts_t sts
);
  import lsp_pkg::*;

  lsp_state_t state;
  lsp_state_t state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    ctl.start      = 1'b0;
    ctl.op         = in_cmd;
    ctl.purge_run  = 1'b0;
    ctl.load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.start  = 1'b1;
          state_next = (in_cmd == CMD_PURGE) ? ST_PURGE : ST_RESULT;
        end
      end
      ST_PURGE: begin
        ctl.purge_run = 1'b1;
        if (sts.purge_done) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          ctl.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/lifo_stack_with_purge_unit.sv */
// Push, pop and no-op pass from accept through the result state into the result register.
// A purge first walks the held entries in the purge state: the walk
// reads one entry per cycle through the single memory read port and writes survivors back.
// Intake takes one command at a time and stalls during a purge and while a result waits.
// Reset clears fill level and control; memory contents are left as they are.
// ----------------------------------------------------------------------------
// LIFO stack with purge - top level
// Bounded word stack with push, pop and remove-all-matching commands.
// ----------------------------------------------------------------------------
module lifo_stack_with_purge_unit #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 64
) (
  input logic      clk,
  input logic      rst,
  lsp_in_if.sink   in_ch,
  lsp_out_if.source out_ch
);
  import lsp_pkg::*;

  lsp_ctl_t ctl;
  lsp_sts_t sts;

  lsp_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (lsp_cmd_t'(in_ch.cmd)),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  lsp_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .value         (in_ch.value),
    .top_value     (out_ch.top_value),
    .stack_empty   (out_ch.stack_empty),
    .fill_level    (out_ch.fill_level),
    .removed_count (out_ch.removed_count),
    .overflow      (out_ch.overflow),
    .underflow     (out_ch.underflow)
  );

endmodule

/* rtl/lsp_checker.sv */
// ----------------------------------------------------------------------------
// LIFO stack with purge - port checker
// Checks result consistency and intake sequencing seen at the top ports.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_purge_unit_macros.svh"

module lsp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lsp_pkg::DATA_BITS-1:0]  top_value,
  input logic                           stack_empty,
  input logic [lsp_pkg::LEVEL_BITS-1:0] fill_level,
  input logic [lsp_pkg::LEVEL_BITS-1:0] removed_count,
  input logic                           overflow,
  input logic                           underflow
);
  import lsp_pkg::*;

  // an empty stack shows level zero and a zero top
  `LSP_ASSERT_NOW(a_empty_view, out_valid && stack_empty, fill_level == '0 && top_value == '0)
  // a refused pop leaves the stack empty
  `LSP_ASSERT_NOW(a_underflow_empty, out_valid && underflow, stack_empty)
  // error flags exclude each other and any purge count
  `LSP_ASSERT_NOW(a_flags_exclusive, out_valid && (overflow || underflow),
                  !(overflow && underflow) && removed_count == '0)
  // one item at a time: intake closes right after an accept
  `LSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a stalled result holds
  `LSP_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
                   out_valid && $stable(top_value) && $stable(fill_level))

endmodule

bind lifo_stack_with_purge_unit lsp_checker u_lsp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .top_value     (out_ch.top_value),
  .stack_empty   (out_ch.stack_empty),
  .fill_level    (out_ch.fill_level),
  .removed_count (out_ch.removed_count),
  .overflow      (out_ch.overflow),
  .underflow     (out_ch.underflow)
);

/* sim/lifo_stack_with_purge_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIFO stack with purge - testbench
// Drives push, pop, purge and no-op items into the stack unit and predicts
// the stack contents for every accepted item. Each result is compared field
// by field with the prediction. A short directed run covers underflow,
// empty purges, order-keeping purges and extreme words. Random phases fill
// to overflow, drain to underflow and purge from a small pool of words.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module lifo_stack_with_purge_unit_test;
  import lsp_pkg::*;

  localparam int DEPTH        = 64;
  localparam int WORD_BITS    = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 650;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 120;
  localparam int TAIL_CYCLES  = 80;
  localparam int POOL_SIZE    = 6;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN, PH_PURGE} phase_kind_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]  top_value;
    logic                  stack_empty;
    logic [LEVEL_BITS-1:0] fill_level;
    logic [LEVEL_BITS-1:0] removed_count;
    logic                  overflow;
    logic                  underflow;
  } stack_result_t;

  // Mirror of the stack contents plus the queue of results still owed.
  class stack_scoreboard;
    logic [DATA_BITS-1:0] entries [DEPTH];
    int unsigned          held;
    stack_result_t        owed_q[$];
    int unsigned          mismatches;
    int unsigned          results_seen;

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_command(lsp_cmd_t op, logic [DATA_BITS-1:0] word);
      stack_result_t r;
      int unsigned   wr;
      r = '0;
      case (op)
        CMD_PUSH: begin
          if (held >= DEPTH) begin
            r.overflow = 1'b1;
          end else begin
            entries[held] = word;
            held++;
          end
        end
        CMD_POP: begin
          if (held == 0) r.underflow = 1'b1;
          else held--;
        end
        CMD_PURGE: begin
          // compact survivors toward the bottom, keeping their order
          wr = 0;
          for (int unsigned rd = 0; rd < held; rd++) begin
            if (entries[rd] !== word) begin
              entries[wr] = entries[rd];
              wr++;
            end
          end
          r.removed_count = LEVEL_BITS'(held - wr);
          held = wr;
        end
        default: ;
      endcase
      r.top_value   = (held != 0) ? entries[held-1] : '0;
      r.stack_empty = (held == 0);
      r.fill_level  = LEVEL_BITS'(held);
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [DATA_BITS-1:0] want,
                                logic [DATA_BITS-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t want;
      results_seen++;
      if (owed_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual top %h level %0d",
                 $time, got.top_value, got.fill_level);
        return;
      end
      want = owed_q.pop_front();
      compare_field("top_value", want.top_value, got.top_value);
      compare_field("stack_empty", DATA_BITS'(want.stack_empty), DATA_BITS'(got.stack_empty));
      compare_field("fill_level", DATA_BITS'(want.fill_level), DATA_BITS'(got.fill_level));
      compare_field("removed_count", DATA_BITS'(want.removed_count),
                    DATA_BITS'(got.removed_count));
      compare_field("overflow", DATA_BITS'(want.overflow), DATA_BITS'(got.overflow));
      compare_field("underflow", DATA_BITS'(want.underflow), DATA_BITS'(got.underflow));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  lsp_in_if  cmd_ch ();
  lsp_out_if res_ch ();

  lifo_stack_with_purge_unit #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  stack_scoreboard      sb = new();
  logic [DATA_BITS-1:0] word_pool [POOL_SIZE];
  int unsigned          burst_left;
  int unsigned          quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe both channels at the rising edge; watch for a hung block.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready)
        sb.note_command(lsp_cmd_t'(cmd_ch.cmd), cmd_ch.value);
      if (res_ch.valid && res_ch.ready)
        sb.check_result('{top_value:     res_ch.top_value,
                          stack_empty:   res_ch.stack_empty,
                          fill_level:    res_ch.fill_level,
                          removed_count: res_ch.removed_count,
                          overflow:      res_ch.overflow,
                          underflow:     res_ch.underflow});
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: switch between stall patterns, with one long hold-off.
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned tick;
    bit          hold_done;
    mode_left = 0;
    tick = 0;
    hold_done = 1'b0;
    mode = RX_STEADY;
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
        // hold off so the block backs up and stalls its intake
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(3));
          mode_left = $urandom_range(80, 20);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_STEADY: res_ch.ready <= 1'b1;
          RX_COIN:   res_ch.ready <= 1'($urandom_range(1));
          RX_SPARSE: res_ch.ready <= ($urandom_range(3) == 0);
          default:   res_ch.ready <= (tick % 5 < 2);
        endcase
      end
    end
  end

  task automatic send_item(input lsp_cmd_t op, input logic [DATA_BITS-1:0] word);
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= op;
    cmd_ch.value <= word;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Send with burst shaping: random burst lengths, random gaps between them.
  task automatic offer_item(input lsp_cmd_t op, input logic [DATA_BITS-1:0] word);
    if (burst_left == 0) begin
      idle_for($urandom_range(8, 1));
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
    end
    burst_left--;
    send_item(op, word);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_BITS-1:0] pick_word(input int unsigned pool_pct);
    if ($urandom_range(99) < pool_pct) return word_pool[$urandom_range(POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic lsp_cmd_t pick_op(input int unsigned p_push, input int unsigned p_pop,
                                       input int unsigned p_purge);
    int unsigned r;
    r = $urandom_range(99);
    if (r < p_push) return CMD_PUSH;
    if (r < p_push + p_pop) return CMD_POP;
    if (r < p_push + p_pop + p_purge) return CMD_PURGE;
    return CMD_NOP;
  endfunction

  task automatic run_directed();
    send_item(CMD_POP, '0);
    send_item(CMD_PURGE, '1);
    send_item(CMD_NOP, '1);
    send_item(CMD_PUSH, '1);
    send_item(CMD_PUSH, '0);
    send_item(CMD_PUSH, '1);
    send_item(CMD_PUSH, 64'h5555_5555_5555_5555);
    send_item(CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(CMD_NOP, 64'h0123_4567_89AB_CDEF);
    // drop both all-ones words, keep the rest in order
    send_item(CMD_PURGE, '1);
    send_item(CMD_PURGE, 64'hDEAD_BEEF_0000_0001);
    send_item(CMD_POP, '1);
    send_item(CMD_PURGE, '0);
    send_item(CMD_POP, '0);
    send_item(CMD_POP, '0);
    send_item(CMD_PUSH, 64'h1);
    send_item(CMD_PUSH, 64'h1);
    send_item(CMD_PUSH, 64'h1);
    send_item(CMD_PURGE, 64'h1);
    send_item(CMD_PUSH, 64'h8000_0000_0000_0000);
    send_item(CMD_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(CMD_POP, 64'h8000_0000_0000_0000);
    send_item(CMD_POP, '1);
    wait_until_drained();
  endtask

  task automatic run_random();
    phase_kind_t kind;
    lsp_cmd_t    op;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned k;
    sent = 0;
    k = 0;
    word_pool[0] = '0;
    word_pool[1] = '1;
    word_pool[2] = 64'h8000_0000_0000_0001;
    for (int i = 3; i < POOL_SIZE; i++) word_pool[i] = {$urandom, $urandom};
    while (sent < RANDOM_ITEMS) begin
      kind = phase_kind_t'(k % 4);
      if (kind == PH_FILL || kind == PH_DRAIN) phase_len = $urandom_range(100, 80);
      else phase_len = $urandom_range(70, 30);
      for (int unsigned i = 0; i < phase_len; i++) begin
        case (kind)
          PH_FILL:  op = pick_op(90, 3, 5);
          PH_MIXED: op = pick_op(45, 35, 15);
          PH_DRAIN: op = pick_op(10, 80, 8);
          default:  op = pick_op(50, 10, 35);
        endcase
        offer_item(op, pick_word((kind == PH_PURGE || op == CMD_PURGE) ? 85 : 40));
        sent++;
      end
      // pause until the block has delivered everything owed
      wait_until_drained();
      k++;
    end
  endtask

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd   = CMD_NOP;
    cmd_ch.value = '0;
    burst_left = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    wait_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
